FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the clipper RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hw/rtl/mslc_pkg.sv
// Package for the midpoint subdivision line clipper: codes, types.
// Depends on nothing.
package mslc_pkg;
  localparam int unsigned CODE_TOP    = 3;
  localparam int unsigned CODE_BOTTOM = 2;
  localparam int unsigned CODE_RIGHT  = 1;
  localparam int unsigned CODE_LEFT   = 0;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  // class of a segment decided at the front end
  typedef enum logic [1:0] {
    CLS_ACCEPT = 2'd0,
    CLS_REJECT = 2'd1,
    CLS_SEARCH = 2'd2
  } seg_class_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_LOAD1 = 3'd1,
    ST_RUN   = 3'd2,
    ST_DONE1 = 3'd3,
    ST_RUN2  = 3'd4,
    ST_DONE2 = 3'd5,
    ST_OUT   = 3'd6
  } bis_state_t;
endpackage

FILE: hw/rtl/mslc_if.sv
// Valid/ready channel interface for the clipper.
// Depends on nothing; payload type is a parameter.
interface mslc_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/mslc_front.sv
// Front end: accept segment, compute outcodes, classify, push queue entry.
// Depends on mslc_pkg.
module mslc_front import mslc_pkg::*; #(
  parameter int W = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] sx, sy, ex, ey,
  input  logic signed [W-1:0] wl, wb, wr, wt,
  output logic                q_valid,
  input  logic                q_ready,
  output seg_class_t          q_cls,
  output logic [4*W-1:0]      q_pts
);
  logic [3:0] cs, ce;
  function automatic logic [3:0] oc(input logic signed [W-1:0] x, y,
                                    input logic signed [W-1:0] l, b, r, t);
    logic [3:0] c;
    c = '0;
    c[CODE_TOP] = y > t;
    c[CODE_BOTTOM] = y < b;
    c[CODE_RIGHT] = x > r;
    c[CODE_LEFT] = x < l;
    return c;
  endfunction
  assign cs = oc(sx, sy, wl, wb, wr, wt);
  assign ce = oc(ex, ey, wl, wb, wr, wt);
  assign in_ready = !q_valid || q_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_pts <= {sx, sy, ex, ey};
      if (cs == 4'd0 && ce == 4'd0) q_cls <= CLS_ACCEPT;
      else if ((cs & ce) != 4'd0)   q_cls <= CLS_REJECT;
      else                          q_cls <= CLS_SEARCH;
    end
  end
endmodule

FILE: hw/rtl/mslc_back.sv
// Back end: bounded bisection search, one midpoint per cycle, output register.
// Depends on mslc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mslc_back import mslc_pkg::*; #(
  parameter int W = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  seg_class_t          q_cls,
  input  logic [4*W-1:0]      q_pts,
  input  logic signed [W-1:0] wl, wb, wr, wt,
  output logic                o_valid,
  input  logic                o_ready,
  output logic                o_vis,
  output logic [4*W-1:0]      o_pts
);
  localparam int SB = $clog2(W + 3);
  localparam logic [SB-1:0] LAST = SB'(W + 2);

  bis_state_t state, state_next;
  logic signed [W-1:0] ax, ay, bx, by, qx, qy, cpx, cpy;
  logic [SB-1:0] step;
  logic found;

  function automatic logic [3:0] oc(input logic signed [W-1:0] x, y,
                                    input logic signed [W-1:0] l, b, r, t);
    logic [3:0] c;
    c = '0;
    c[CODE_TOP] = y > t;
    c[CODE_BOTTOM] = y < b;
    c[CODE_RIGHT] = x > r;
    c[CODE_LEFT] = x < l;
    return c;
  endfunction

  logic [3:0] ca, cb, cm;
  logic signed [W:0] dx, dy, sxm, sym;
  logic signed [W-1:0] mx, my;
  logic adj, run;
  assign ca = oc(ax, ay, wl, wb, wr, wt);
  assign cb = oc(bx, by, wl, wb, wr, wt);
  assign dx = {ax[W-1], ax} - {bx[W-1], bx};
  assign dy = {ay[W-1], ay} - {by[W-1], by};
  assign adj = dx >= -1 && dx <= 1 && dy >= -1 && dy <= 1;
  // arithmetic shift of the widened sum floors toward minus infinity
  assign sxm = {ax[W-1], ax} + {bx[W-1], bx};
  assign sym = {ay[W-1], ay} + {by[W-1], by};
  assign mx = sxm[W:1];
  assign my = sym[W:1];
  assign cm = oc(mx, my, wl, wb, wr, wt);
  assign run = state == ST_RUN || state == ST_RUN2;

  always_comb begin
    state_next = state;
    q_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_next = (q_cls == CLS_SEARCH) ? ST_RUN : ST_OUT;
      end
      ST_RUN, ST_RUN2: begin
        if (ca == 4'd0 || (ca & cb) != 4'd0 || adj || step == LAST)
          state_next = (state == ST_RUN) ? ST_DONE1 : ST_DONE2;
      end
      ST_DONE1: state_next = found ? ST_RUN2 : ST_OUT;
      ST_DONE2: state_next = ST_OUT;
      ST_OUT:   if (o_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // finish rule applied to the held pair when a search ends
  logic fin_ok;
  logic signed [W-1:0] fin_x, fin_y;
  always_comb begin
    fin_ok = 1'b0;
    fin_x = ax;
    fin_y = ay;
    if (ca == 4'd0) fin_ok = 1'b1;
    else if ((ca & cb) == 4'd0 && adj && cb == 4'd0) begin
      fin_ok = 1'b1;
      fin_x = bx;
      fin_y = by;
    end
  end

  // start result held separately across the second search
  logic signed [W-1:0] rsx, rsy;

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      step <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (q_valid) begin
          qx <= q_pts[2*W-1:W];
          qy <= q_pts[W-1:0];
          ax <= q_pts[4*W-1:3*W];
          ay <= q_pts[3*W-1:2*W];
          bx <= q_pts[2*W-1:W];
          by <= q_pts[W-1:0];
          step <= '0;
          found <= q_cls == CLS_ACCEPT;
          o_pts <= q_pts;
        end
        ST_RUN, ST_RUN2: begin
          if (state_next == state) begin
            step <= step + 1'b1;
            if (cm == 4'd0 || (ca & cm) == 4'd0) begin
              bx <= mx; by <= my;
            end else begin
              ax <= mx; ay <= my;
            end
          end else begin
            found <= fin_ok;
            cpx <= fin_x;
            cpy <= fin_y;
          end
        end
        ST_DONE1: begin
          // search end point toward clipped start
          ax <= qx; ay <= qy; bx <= cpx; by <= cpy;
          step <= '0;
        end
        ST_DONE2: o_pts <= {rsx, rsy, cpx, cpy};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE1) begin
      rsx <= cpx;
      rsy <= cpy;
    end
  end

  assign o_valid = state == ST_OUT;
  assign o_vis = found;

  `ASSERT_IMP(a_out_hold, clk, rst, o_valid && !o_ready, state_next == ST_OUT, "out dropped")
  `ASSERT_IMP(a_step_bound, clk, rst, run, step <= LAST, "step overrun")
  `ASSERT_NXT(a_out_stable, clk, rst, o_valid && !o_ready, o_valid && $stable(o_pts), "out moved")
  `ASSERT_IMP(a_ready_idle, clk, rst, q_ready, state == ST_IDLE, "ready outside idle")
endmodule

FILE: hw/rtl/mslc_out.sv
// Output stage: zero the point fields of invisible results.
// Depends on mslc_pkg.
module mslc_out import mslc_pkg::*; #(
  parameter int W = 12
) (
  input  logic           vis,
  input  logic [4*W-1:0] pts,
  output logic [4*W-1:0] pts_out
);
  assign pts_out = vis ? pts : '0;
endmodule

FILE: hw/rtl/midpoint_subdivision_line_clipper.sv
// Top level of the midpoint subdivision line clipper.
// Depends on mslc_pkg, mslc_if, mslc_front, mslc_back, mslc_out.
//
//   channel   dir  payload
//   seg_in    in   start_x start_y end_x end_y
//   clip_out  out  visible clip_start_x clip_start_y clip_end_x clip_end_y
//   cfg       in   cfg_we cfg_index cfg_data (window registers)
//
// A trivially accepted or rejected segment skips the search in the back end;
// a bisected one runs up to two searches in turn on the single midpoint
// unit, which does one step per cycle. The front register takes the next
// segment while the back end works. Reset (rst, synchronous) clears the
// window to zero and empties both stages. A stalled output holds the back end.
module midpoint_subdivision_line_clipper import mslc_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [COORD_BITS-1:0] cfg_data,
  mslc_if.sink seg_in,
  mslc_if.source clip_out
);
  localparam int W = COORD_BITS;
  logic signed [W-1:0] wl, wb, wr, wt;

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wl <= '0; wb <= '0; wr <= '0; wt <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT:   wl <= cfg_data;
        REG_BOTTOM: wb <= cfg_data;
        REG_RIGHT:  wr <= cfg_data;
        REG_TOP:    wt <= cfg_data;
        default: ;
      endcase
    end
  end

  logic q_valid, q_ready, vis;
  seg_class_t q_cls;
  logic [4*W-1:0] q_pts, b_pts, o_pts;

  mslc_front #(.W(W)) u_front (
    .clk, .rst,
    .in_valid(seg_in.valid), .in_ready(seg_in.ready),
    .sx(seg_in.data.start_x), .sy(seg_in.data.start_y),
    .ex(seg_in.data.end_x), .ey(seg_in.data.end_y),
    .wl, .wb, .wr, .wt,
    .q_valid, .q_ready, .q_cls, .q_pts
  );

  mslc_back #(.W(W)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cls, .q_pts,
    .wl, .wb, .wr, .wt,
    .o_valid(clip_out.valid), .o_ready(clip_out.ready),
    .o_vis(vis), .o_pts(b_pts)
  );

  mslc_out #(.W(W)) u_out (.vis, .pts(b_pts), .pts_out(o_pts));

  assign clip_out.data.visible = vis;
  assign {clip_out.data.clip_start_x, clip_out.data.clip_start_y,
          clip_out.data.clip_end_x, clip_out.data.clip_end_y} = o_pts;
endmodule
